// ----- sv/nzf_pkg.sv -----
// ----------------------------------------------------------------------------
// nzf_pkg: shared types, constants and helpers of the net-zero filter
// Widths, register indexes, reset values and saturation helpers.
// ----------------------------------------------------------------------------
package nzf_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int SUM_W      = 24;
  localparam int CNT_W      = 10;
  localparam int THR_W      = 15;
  localparam int TMO_W      = 10;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 15;

  // Log / power datapath
  localparam int MANT_W   = 31;                 // Q30 mantissa in [1,2)
  localparam int FRAC_W   = 16;                 // log fraction bits
  localparam int EXP_W    = 5;                  // log integer part
  localparam int LOG_W    = EXP_W + FRAC_W;
  localparam int E_W      = 27;                 // weighted log sum
  localparam int ROOT_W   = 32;
  localparam int RAD_W    = 2 * ROOT_W;
  localparam int CORR_W   = 20;
  localparam int DIV_REM_W = 7;
  localparam int ITER_W   = 5;

  localparam logic [DIV_REM_W:0] LOG_DIVISOR = 8'd100;
  localparam logic [E_W-1:0]     LOG_ROUND   = 27'd50;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MOTION_THR = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_THR   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DAMP_STEP  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_QUIET_TMO  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BACKOFF    = 3'd4;

  // Reset values
  localparam logic [THR_W-1:0] RST_MOTION_THR = 15'd82;
  localparam logic [THR_W-1:0] RST_ZERO_THR   = 15'd82;
  localparam logic [THR_W-1:0] RST_DAMP_STEP  = 15'd82;
  localparam logic [TMO_W-1:0] RST_QUIET_TMO  = 10'd50;
  localparam logic [TMO_W-1:0] RST_BACKOFF    = 10'd40;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_DAMP,
    ST_OUT
  } nzf_state_t;

  typedef enum logic [3:0] {
    D_IDLE,
    D_NORM,
    D_SQ_GO,
    D_SQ_WAIT,
    D_ACC,
    D_DIV,
    D_RT_GO,
    D_RT_WAIT,
    D_FIN,
    D_DONE
  } damp_state_t;

  // Saturate a widened sum back to SUM_W bits
  function automatic logic signed [SUM_W-1:0] sat_sum(input logic signed [SUM_W:0] v);
    logic signed [SUM_W-1:0] r;
    r = v[SUM_W-1:0];
    if (v[SUM_W] != v[SUM_W-1]) begin
      r = v[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end
    return r;
  endfunction

  // Saturate to the 16 bit output range
  function automatic logic signed [SAMPLE_W-1:0] sat16(input logic signed [SUM_W+1:0] v);
    logic signed [SAMPLE_W-1:0] r;
    r = v[SAMPLE_W-1:0];
    if (v > 26'sd32767) begin
      r = 16'sh7FFF;
    end else if (v < -26'sd32768) begin
      r = 16'sh8000;
    end
    return r;
  endfunction

  // Index of the highest set bit
  function automatic logic [EXP_W-1:0] top_index(input logic [SUM_W-1:0] v);
    logic [EXP_W-1:0] idx;
    idx = '0;
    for (int i = 0; i < SUM_W; i++) begin
      if (v[i]) idx = EXP_W'(i);
    end
    return idx;
  endfunction

endpackage

// ----- sv/accelerometer_net_zero_filter.sv -----
// ----------------------------------------------------------------------------
// accelerometer_net_zero_filter: net-zero correction of accelerometer samples
// Keeps a saturating running sum and two tick counters; clears the residual
// near zero and otherwise damps the sum after a quiet timeout.
// ----------------------------------------------------------------------------
// Channel   Direction  Payload
// in_       request    tdata[15:0] sample (signed Q3.12)
// out_      result     tdata[15:0] filtered (signed Q3.12)
// cfg_      write      idx[2:0] register, data[14:0] value
//
// A sample without damping passes through ST_EVAL and ST_OUT to the output register.
// A damping tick with a nonzero sum runs the bit-serial squarer (two logs of
// 16 squarings), a serial division by 100 and the serial root (16 roots).
// One sample is in work at a time; in_tready rises once the result sits in
// the output register, which holds it while out_tready is low.
// Reset restores the register defaults and clears the sum and counters.
// ----------------------------------------------------------------------------
module accelerometer_net_zero_filter import nzf_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [SAMPLE_W-1:0]   in_tdata,    // [15:0] sample
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [SAMPLE_W-1:0]   out_tdata,   // [15:0] filtered
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  nzf_state_t st_r, st_nxt;
  logic [THR_W-1:0] mth_r, zth_r, dstep_r;
  logic [TMO_W-1:0] qt_r, bo_r;

  logic signed [SAMPLE_W-1:0] sample_r, sample_nxt;
  logic signed [SUM_W-1:0]    sum_r, sum_nxt;
  logic [CNT_W-1:0]           tsm_r, tsm_nxt, tsc_r, tsc_nxt;
  logic signed [SAMPLE_W-1:0] res_r, res_nxt;
  logic [SAMPLE_W-1:0]        out_r, out_nxt;
  logic                       ov_r, ov_nxt;

  logic signed [SAMPLE_W-1:0] a;
  logic [SAMPLE_W:0]          mag_a;
  logic [SUM_W-1:0]           mag_s;
  logic                       zero_hit, quiet;
  logic                       damp_start, damp_done;
  logic [CORR_W-1:0]          corr;
  logic signed [CORR_W:0]     corr_s;

  nzf_damp u_damp (
    .clk   (clk),
    .rst_n (rst_n),
    .start (damp_start),
    .mag   (mag_s),
    .step  (dstep_r),
    .done  (damp_done),
    .corr  (corr)
  );

  assign a        = $signed(in_tdata);
  assign mag_a    = a[SAMPLE_W-1] ? (~{1'b1, a} + 1'b1) : {1'b0, a};
  assign mag_s    = sum_r[SUM_W-1] ? (~sum_r + 1'b1) : sum_r;
  assign zero_hit = (mag_s < SUM_W'(zth_r));
  assign quiet    = (tsc_r > qt_r) || (tsm_r > qt_r);
  assign corr_s   = sum_r[SUM_W-1] ? -$signed({1'b0, corr}) : $signed({1'b0, corr});

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mth_r   <= RST_MOTION_THR;
      zth_r   <= RST_ZERO_THR;
      dstep_r <= RST_DAMP_STEP;
      qt_r    <= RST_QUIET_TMO;
      bo_r    <= RST_BACKOFF;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_MOTION_THR: mth_r   <= cfg_data;
        CFG_ZERO_THR:   zth_r   <= cfg_data;
        CFG_DAMP_STEP:  dstep_r <= cfg_data;
        CFG_QUIET_TMO:  qt_r    <= cfg_data[TMO_W-1:0];
        CFG_BACKOFF:    bo_r    <= cfg_data[TMO_W-1:0];
        default: ;
      endcase
    end
  end

  // State, filter state and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= ST_IDLE;
      sum_r <= '0;
      tsm_r <= '0;
      tsc_r <= '0;
      ov_r  <= 1'b0;
    end else begin
      st_r  <= st_nxt;
      sum_r <= sum_nxt;
      tsm_r <= tsm_nxt;
      tsc_r <= tsc_nxt;
      ov_r  <= ov_nxt;
    end
    sample_r <= sample_nxt;
    res_r    <= res_nxt;
    out_r    <= out_nxt;
  end

  // Next state
  always_comb begin
    st_nxt     = st_r;
    sample_nxt = sample_r;
    sum_nxt    = sum_r;
    tsm_nxt    = tsm_r;
    tsc_nxt    = tsc_r;
    res_nxt    = res_r;
    out_nxt    = out_r;
    ov_nxt     = ov_r;
    damp_start = 1'b0;
    in_tready  = 1'b0;

    // Drop the output once taken
    if (ov_r && out_tready) begin
      ov_nxt = 1'b0;
    end

    case (st_r)
      // Take a sample: advance counters and the running sum
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          sample_nxt = a;
          tsm_nxt    = (tsm_r == '1) ? tsm_r : tsm_r + 1'b1;
          tsc_nxt    = (tsc_r == '1) ? tsc_r : tsc_r + 1'b1;
          if (mag_a >= (SAMPLE_W+1)'(mth_r)) begin
            tsm_nxt = '0;
          end
          sum_nxt = sat_sum($signed({sum_r[SUM_W-1], sum_r}) + (SUM_W+1)'(a));
          st_nxt  = ST_EVAL;
        end
      end
      // Remove the residual, start damping or pass the sample
      ST_EVAL: begin
        if (zero_hit) begin
          res_nxt = sat16((SUM_W+2)'(sample_r) - (SUM_W+2)'(sum_r));
          sum_nxt = '0;
          tsc_nxt = '0;
          st_nxt  = ST_OUT;
        end else if (quiet) begin
          damp_start = 1'b1;
          st_nxt     = ST_DAMP;
        end else begin
          res_nxt = sample_r;
          st_nxt  = ST_OUT;
        end
      end
      // Apply the damping term
      ST_DAMP: begin
        if (damp_done) begin
          res_nxt = sat16((SUM_W+2)'(sample_r) - (SUM_W+2)'(corr_s));
          sum_nxt = sat_sum((SUM_W+1)'(sum_r) - (SUM_W+1)'(corr_s));
          tsc_nxt = bo_r;
          st_nxt  = ST_OUT;
        end
      end
      // Hold until the output register is free
      ST_OUT: begin
        if (!ov_r || out_tready) begin
          out_nxt = res_r;
          ov_nxt  = 1'b1;
          st_nxt  = ST_IDLE;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = out_r;

  // A damping result only arrives while waiting for one
  a_damp_done: assert property (@(posedge clk) disable iff (!rst_n)
    damp_done |-> st_r == ST_DAMP)
    else $error("damping result outside damping state");

  // A residual removal clears the sum and the correction counter
  a_zero_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_EVAL && zero_hit) |=> (sum_r == '0 && tsc_r == '0))
    else $error("residual removal did not clear state");

  // An accepted sample is evaluated in the next cycle
  a_accept_eval: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> st_r == ST_EVAL)
    else $error("accepted sample not evaluated");

  // A result is loaded only when the output register is free or drained
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_OUT && ov_r && !out_tready) |=> (ov_r && $stable(out_r)))
    else $error("pending result overwritten");

endmodule

// ----- sv/nzf_sqr.sv -----
// ----------------------------------------------------------------------------
// nzf_sqr: bit-serial squarer
// Shift-and-add multiply of the mantissa by itself, one bit per cycle.
// ----------------------------------------------------------------------------
module nzf_sqr import nzf_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [MANT_W-1:0]     op,
  output logic                  done,
  output logic [2*MANT_W-1:0]   prod
);

  logic [MANT_W-1:0] mc_r, mp_r, lo_r;
  logic [MANT_W:0]   hi_r;
  logic [ITER_W-1:0] cnt_r;
  logic              busy_r, done_r;
  logic [MANT_W+1:0] add;

  // Add the multiplicand when the current multiplier bit is set
  assign add = {1'b0, hi_r} + (mp_r[0] ? {2'b00, mc_r} : '0);

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r && cnt_r == ITER_W'(MANT_W - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  // Datapath: shift the partial product right one bit per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      mc_r <= op;
      mp_r <= op;
      hi_r <= '0;
      lo_r <= '0;
    end else if (busy_r) begin
      hi_r <= add[MANT_W+1:1];
      lo_r <= {add[0], lo_r[MANT_W-1:1]};
      mp_r <= {1'b0, mp_r[MANT_W-1:1]};
    end
  end

  assign done = done_r;
  assign prod = {hi_r[MANT_W-1:0], lo_r};

endmodule

// ----- sv/nzf_sqrt.sv -----
// ----------------------------------------------------------------------------
// nzf_sqrt: digit-serial integer square root
// Restoring root, two radicand bits per cycle, one root bit per cycle.
// ----------------------------------------------------------------------------
module nzf_sqrt import nzf_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [RAD_W-1:0]   rad,
  output logic               done,
  output logic [ROOT_W-1:0]  root
);

  logic [RAD_W-1:0]  rad_r;
  logic [ROOT_W+3:0] rem_r;
  logic [ROOT_W-1:0] q_r;
  logic [ITER_W-1:0] cnt_r;
  logic              busy_r, done_r;
  logic [ROOT_W+3:0] t, trial;
  logic              ge;

  // Bring down two bits and try the next root bit
  assign t     = {rem_r[ROOT_W+1:0], rad_r[RAD_W-1:RAD_W-2]};
  assign trial = {2'b00, q_r, 2'b01};
  assign ge    = (t >= trial);

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r && cnt_r == ITER_W'(ROOT_W - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rad_r <= rad;
      rem_r <= '0;
      q_r   <= '0;
    end else if (busy_r) begin
      rad_r <= {rad_r[RAD_W-3:0], 2'b00};
      rem_r <= ge ? (t - trial) : t;
      q_r   <= {q_r[ROOT_W-2:0], ge};
    end
  end

  assign done = done_r;
  assign root = q_r;

endmodule

// ----- sv/nzf_damp.sv -----
// ----------------------------------------------------------------------------
// nzf_damp: damping term sequencer
// corr = round(step * (mag/step)^0.33) via log2, weighted sum, serial /100
// and a chain of square roots for the fractional power of two.
// ----------------------------------------------------------------------------
module nzf_damp import nzf_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [SUM_W-1:0]  mag,
  input  logic [THR_W-1:0]  step,
  output logic              done,
  output logic [CORR_W-1:0] corr
);

  damp_state_t st_r, st_nxt;
  logic [SUM_W-1:0]     v_r, v_nxt, mag_r, mag_nxt;
  logic                 second_r, second_nxt;
  logic [MANT_W-1:0]    m_r, m_nxt;
  logic [FRAC_W-1:0]    frac_r, frac_nxt;
  logic [EXP_W-1:0]     n_r, n_nxt, top;
  logic [ITER_W-1:0]    it_r, it_nxt;
  logic [E_W-1:0]       e_r, e_nxt;
  logic [DIV_REM_W-1:0] rem_r, rem_nxt;
  logic [ROOT_W-1:0]    r_r, r_nxt;
  logic [3:0]           k_r, k_nxt;
  logic [CORR_W-1:0]    corr_r, corr_nxt;

  logic                 sqr_start, sqr_done, rt_start, rt_done;
  logic [2*MANT_W-1:0]  prod;
  logic [ROOT_W-1:0]    root;
  logic [RAD_W-1:0]     rad;
  logic [ROOT_W:0]      rr;
  logic [LOG_W-1:0]     lg;
  logic [E_W-1:0]       wlog;
  logic [DIV_REM_W:0]   dt;
  logic [RAD_W-1:0]     shifted;

  nzf_sqr u_sqr (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sqr_start),
    .op    (m_r),
    .done  (sqr_done),
    .prod  (prod)
  );

  nzf_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (rt_start),
    .rad   (rad),
    .done  (rt_done),
    .root  (root)
  );

  assign top  = top_index(v_r);
  assign lg   = {n_r, frac_r};
  assign wlog = second_r ? ({1'b0, lg, 5'b0} + E_W'(lg))
                         : ({lg, 6'b0} + {5'b0, lg, 1'b0} + E_W'(lg));
  assign dt   = {rem_r, e_r[E_W-1]};
  assign rr   = e_r[k_r] ? {r_r, 1'b0} : {1'b0, r_r};
  assign rad  = {1'b0, rr, 30'b0};
  assign shifted = ({{ROOT_W{1'b0}}, r_r} << e_r[LOG_W-1:FRAC_W]) + (RAD_W'(1) << 29);

  // State register and payload
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= D_IDLE;
    end else begin
      st_r <= st_nxt;
    end
    v_r      <= v_nxt;
    mag_r    <= mag_nxt;
    second_r <= second_nxt;
    m_r      <= m_nxt;
    frac_r   <= frac_nxt;
    n_r      <= n_nxt;
    it_r     <= it_nxt;
    e_r      <= e_nxt;
    rem_r    <= rem_nxt;
    r_r      <= r_nxt;
    k_r      <= k_nxt;
    corr_r   <= corr_nxt;
  end

  // Next state and outputs
  always_comb begin
    st_nxt     = st_r;
    v_nxt      = v_r;
    mag_nxt    = mag_r;
    second_nxt = second_r;
    m_nxt      = m_r;
    frac_nxt   = frac_r;
    n_nxt      = n_r;
    it_nxt     = it_r;
    e_nxt      = e_r;
    rem_nxt    = rem_r;
    r_nxt      = r_r;
    k_nxt      = k_r;
    corr_nxt   = corr_r;
    sqr_start  = 1'b0;
    rt_start   = 1'b0;
    done       = 1'b0;
    case (st_r)
      D_IDLE: begin
        if (start) begin
          mag_nxt    = mag;
          second_nxt = 1'b0;
          e_nxt      = LOG_ROUND;
          v_nxt      = (step == '0) ? SUM_W'(1) : SUM_W'(step);
          if (mag == '0) begin
            corr_nxt = '0;
            st_nxt   = D_DONE;
          end else begin
            st_nxt = D_NORM;
          end
        end
      end
      // Normalise to a Q30 mantissa
      D_NORM: begin
        n_nxt    = top;
        m_nxt    = MANT_W'(v_r) << (EXP_W'(MANT_W - 1) - top);
        frac_nxt = '0;
        it_nxt   = '0;
        st_nxt   = D_SQ_GO;
      end
      D_SQ_GO: begin
        sqr_start = 1'b1;
        st_nxt    = D_SQ_WAIT;
      end
      // Square, renormalise when the square reaches two
      D_SQ_WAIT: begin
        if (sqr_done) begin
          m_nxt    = prod[2*MANT_W-1] ? prod[2*MANT_W-1:MANT_W] : prod[2*MANT_W-2:MANT_W-1];
          frac_nxt = {frac_r[FRAC_W-2:0], prod[2*MANT_W-1]};
          it_nxt   = it_r + 1'b1;
          st_nxt   = (it_r == ITER_W'(FRAC_W - 1)) ? D_ACC : D_SQ_GO;
        end
      end
      // Weight the log: 67 for the step, 33 for the magnitude
      D_ACC: begin
        e_nxt = e_r + wlog;
        if (!second_r) begin
          second_nxt = 1'b1;
          v_nxt      = mag_r;
          st_nxt     = D_NORM;
        end else begin
          rem_nxt = '0;
          it_nxt  = '0;
          st_nxt  = D_DIV;
        end
      end
      // Restoring division by 100, one quotient bit per cycle
      D_DIV: begin
        if (dt >= LOG_DIVISOR) begin
          rem_nxt = DIV_REM_W'(dt - LOG_DIVISOR);
        end else begin
          rem_nxt = dt[DIV_REM_W-1:0];
        end
        e_nxt  = {e_r[E_W-2:0], (dt >= LOG_DIVISOR)};
        it_nxt = it_r + 1'b1;
        if (it_r == ITER_W'(E_W - 1)) begin
          r_nxt  = ROOT_W'(1) << 30;
          k_nxt  = '0;
          st_nxt = D_RT_GO;
        end
      end
      D_RT_GO: begin
        rt_start = 1'b1;
        st_nxt   = D_RT_WAIT;
      end
      // Fractional power of two, least significant bit first
      D_RT_WAIT: begin
        if (rt_done) begin
          r_nxt  = root;
          k_nxt  = k_r + 1'b1;
          st_nxt = (k_r == 4'(FRAC_W - 1)) ? D_FIN : D_RT_GO;
        end
      end
      // Scale by the integer part and round half up
      D_FIN: begin
        corr_nxt = shifted[30+CORR_W-1:30];
        st_nxt   = D_DONE;
      end
      D_DONE: begin
        done   = 1'b1;
        st_nxt = D_IDLE;
      end
      default: begin
        st_nxt = D_IDLE;
      end
    endcase
  end

  assign corr = corr_r;

endmodule

// ----- sim/accelerometer_net_zero_filter_test.sv -----
// ----------------------------------------------------------------------------
// Net-zero filter testbench
// Streams accelerometer samples through the filter under several register
// settings and idle patterns, predicts each filtered sample with a local
// fixed-point model of the sum, counters and damping term, and compares the
// results in order.
// ----------------------------------------------------------------------------
module accelerometer_net_zero_filter_test;
  import nzf_pkg::*;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [SAMPLE_W-1:0]   in_tdata;    // [15:0] sample
  logic                  out_tvalid;
  logic                  out_tready;
  logic [SAMPLE_W-1:0]   out_tdata;   // [15:0] filtered
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  accelerometer_net_zero_filter DUT (.*);

  // Shadow registers and filter state
  logic [THR_W-1:0] motion_thr, zero_thr, damp_step;
  logic [TMO_W-1:0] quiet_tmo, backoff;
  longint           acc_sum;
  int unsigned      quiet_ticks, corr_ticks;

  logic [SAMPLE_W-1:0] sample_q[$];
  logic [SAMPLE_W-1:0] filtered_q[$];
  int                  idle_pct, stall_pct;
  int                  mismatches;

  localparam longint SUM_HI = (64'sd1 <<< (SUM_W - 1)) - 1;
  localparam longint SUM_LO = -(64'sd1 <<< (SUM_W - 1));
  localparam int unsigned CNT_TOP = (1 << CNT_W) - 1;

  // Indexes with no register behind them
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

  function automatic longint clip_sum(longint v);
    if (v > SUM_HI) return SUM_HI;
    if (v < SUM_LO) return SUM_LO;
    return v;
  endfunction

  function automatic longint root64(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // log2 in Q16 by repeated squaring of the Q30 mantissa
  function automatic longint unsigned log2_q16(longint unsigned v);
    longint unsigned t, m, frac, n;
    t = v;
    n = 0;
    frac = 0;
    while (t > 1) begin
      t >>= 1;
      n++;
    end
    m = (n >= 30) ? (v >> (n - 30)) : (v << (30 - n));
    for (int i = 0; i < 16; i++) begin
      m = (m * m) >> 30;
      frac <<= 1;
      if (m >= (64'd2 << 30)) begin
        m >>= 1;
        frac |= 1;
      end
    end
    return (n << 16) | frac;
  endfunction

  // Signed damping term step * (|sum|/step)^0.33, rounded half up
  function automatic longint damp_term(longint s);
    longint unsigned mag, stp, e, r, res, n, f;
    mag = (s < 0) ? -s : s;
    stp = (damp_step == 0) ? 1 : damp_step;
    r = 64'd1 << 30;
    if (mag == 0) return 0;
    e = (67 * log2_q16(stp) + 33 * log2_q16(mag) + 50) / 100;
    n = e >> 16;
    f = e & 16'hFFFF;
    for (int k = 0; k < 16; k++) begin
      if ((f >> k) & 1) r <<= 1;
      r = root64(r << 30);
    end
    if (n > 31) n = 31;
    res = ((r << n) + (64'd1 << 29)) >> 30;
    return (s < 0) ? -longint'(res) : longint'(res);
  endfunction

  // Advance the filter state by one tick and return the filtered sample
  function automatic logic [SAMPLE_W-1:0] filter_tick(logic signed [SAMPLE_W-1:0] smp);
    longint a, mag_a, mag_s, res, corr;
    a = smp;
    mag_a = (a < 0) ? -a : a;
    res = a;
    if (quiet_ticks < CNT_TOP) quiet_ticks++;
    if (corr_ticks < CNT_TOP) corr_ticks++;
    if (mag_a >= motion_thr) quiet_ticks = 0;
    acc_sum = clip_sum(acc_sum + a);
    mag_s = (acc_sum < 0) ? -acc_sum : acc_sum;
    if (mag_s < zero_thr) begin
      res = a - acc_sum;
      acc_sum = 0;
      corr_ticks = 0;
    end else if (corr_ticks > quiet_tmo || quiet_ticks > quiet_tmo) begin
      corr = damp_term(acc_sum);
      res = a - corr;
      acc_sum = clip_sum(acc_sum - corr);
      corr_ticks = backoff;
    end
    if (res > 32767) res = 32767;
    if (res < -32768) res = -32768;
    return res[SAMPLE_W-1:0];
  endfunction

  // Clock and one reset at the start
  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Driver: offer queued samples, predict each accepted one
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        filtered_q.push_back(filter_tick(in_tdata));
      end
      if (!in_tvalid || in_tready) begin
        if (sample_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
          in_tdata  <= sample_q.pop_front();
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: random back-pressure, compare against the oldest prediction
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (filtered_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %0d", $time,
                   $signed(out_tdata));
          mismatches++;
        end else if (filtered_q[0] !== out_tdata) begin
          $display("%0t: filtered mismatch, expected %0d, actual %0d", $time,
                   $signed(filtered_q[0]), $signed(out_tdata));
          mismatches++;
          void'(filtered_q.pop_front());
        end else begin
          void'(filtered_q.pop_front());
        end
      end
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    case (idx)
      CFG_MOTION_THR: motion_thr = val;
      CFG_ZERO_THR:   zero_thr   = val;
      CFG_DAMP_STEP:  damp_step  = val;
      CFG_QUIET_TMO:  quiet_tmo  = val[TMO_W-1:0];
      CFG_BACKOFF:    backoff    = val[TMO_W-1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_regs(int mt, int zt, int ds, int qt, int bo);
    write_reg(CFG_MOTION_THR, CFG_DATA_W'(mt));
    write_reg(CFG_ZERO_THR, CFG_DATA_W'(zt));
    write_reg(CFG_DAMP_STEP, CFG_DATA_W'(ds));
    write_reg(CFG_QUIET_TMO, CFG_DATA_W'(qt));
    write_reg(CFG_BACKOFF, CFG_DATA_W'(bo));
  endtask

  // Hold until every sample is taken and every result checked, then let a
  // damping tick that may still be in flight finish
  task automatic drain();
    while (sample_q.size() > 0 || in_tvalid || filtered_q.size() > 0) @(posedge clk);
    repeat (2000) @(posedge clk);
  endtask

  // Mostly small motion around zero, some bursts, some fully random
  function automatic logic [SAMPLE_W-1:0] gen_sample(int bias);
    int k;
    k = $urandom_range(99);
    if (k < 50) return SAMPLE_W'($signed($urandom_range(400)) - 200);
    if (k < 70) return SAMPLE_W'($signed($urandom_range(4000)) - 2000 + bias);
    if (k < 80) return ($urandom_range(1)) ? 16'h7FFF : 16'h8000;
    return SAMPLE_W'($urandom());
  endfunction

  task automatic set_idle(int mode);
    case (mode % 4)
      0: begin idle_pct = 0;  stall_pct = 0;  end
      1: begin idle_pct = 45; stall_pct = 0;  end
      2: begin idle_pct = 0;  stall_pct = 45; end
      default: begin idle_pct = 32; stall_pct = 32; end
    endcase
  endtask

  initial begin
    logic [SAMPLE_W-1:0] directed[$];
    mismatches = 0;
    idle_pct = 0;
    stall_pct = 0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_data = '0;
    motion_thr = RST_MOTION_THR;
    zero_thr   = RST_ZERO_THR;
    damp_step  = RST_DAMP_STEP;
    quiet_tmo  = RST_QUIET_TMO;
    backoff    = RST_BACKOFF;
    acc_sum = 0;
    quiet_ticks = 0;
    corr_ticks = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: field extremes and thresholds either side of 82
    directed = '{16'h0000, 16'h0001, 16'hFFFF, 16'd81, 16'd82, -16'sd82, -16'sd81,
                 16'h7FFF, 16'h8000, 16'h7FFF, 16'h7FFF, 16'd100, -16'sd100,
                 16'h5555, 16'hAAAA};
    foreach (directed[i]) sample_q.push_back(directed[i]);
    drain();

    // Zero step, zero thresholds, timeout 1: damping every other tick, zero sum case
    set_regs(0, 0, 0, 1, 0);
    directed = '{16'd5, -16'sd5, 16'h0000, 16'h7FFF, 16'h8000, 16'd1, 16'hFFFF};
    foreach (directed[i]) sample_q.push_back(directed[i]);
    for (int i = 0; i < 120; i++) sample_q.push_back(gen_sample(0));
    set_idle(1);
    drain();

    // Top values; wide data into the 10 bit registers keeps the low bits
    set_regs(32767, 32767, 32767, 15'h7FFF, 15'h7FFF);
    write_reg(CFG_SPARE_LO, 15'h1234);
    write_reg(CFG_SPARE_HI, 15'h7FFF);
    set_idle(2);
    for (int i = 0; i < 150; i++) sample_q.push_back(gen_sample(0));
    drain();

    // Long positive surge: sum saturates before damping takes over
    set_regs(82, 10, 5000, 1000, 0);
    set_idle(3);
    for (int i = 0; i < 300; i++) sample_q.push_back(($urandom_range(3) == 0) ?
                                                     gen_sample(0) : 16'h7FFF);
    drain();

    // Large step, damping nearly every tick, output saturates
    set_regs(32767, 100, 32767, 1, 0);
    set_idle(0);
    for (int i = 0; i < 80; i++) sample_q.push_back(gen_sample(8000));
    drain();

    // Random settings
    for (int p = 0; p < 6; p++) begin
      set_regs($urandom_range(32767) >> $urandom_range(14), $urandom_range(32767) >>
               $urandom_range(14), 1 + ($urandom_range(32766) >> $urandom_range(14)),
               1 + $urandom_range(120), $urandom_range(60));
      set_idle(p);
      for (int i = 0; i < 120; i++) sample_q.push_back(gen_sample($urandom_range(1) ? 3000 : -3000));
      drain();
    end

    // Back to the reset values for a last stretch
    set_regs(82, 82, 82, 50, 40);
    set_idle(3);
    for (int i = 0; i < 60; i++) sample_q.push_back(gen_sample(0));
    drain();

    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Run limit
  initial begin
    #200000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
